// File: sv/cond_alu_barrel_shifter_flags_core_assert.svh
// Assertion macros shared by the RTL of the conditional ALU core.
`ifndef COND_ALU_BARREL_SHIFTER_FLAGS_CORE_ASSERT_SVH
`define COND_ALU_BARREL_SHIFTER_FLAGS_CORE_ASSERT_SVH

// Checked on every rising edge outside reset.
`define CABSF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cabsf assertion failed");

// Checked on every rising edge, reset included.
`define CABSF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cabsf assertion failed");

`endif

// File: sv/cabsf_pkg.sv
`default_nettype none

package cabsf_pkg;

  localparam int XLEN    = 32;
  localparam int SHAMT_W = 5;
  localparam int AMT_W   = 8;

  // condition codes
  typedef enum logic [3:0] {
    COND_EQ, COND_NE, COND_CS, COND_CC, COND_MI, COND_PL, COND_VS, COND_VC,
    COND_HI, COND_LS, COND_GE, COND_LT, COND_GT, COND_LE, COND_AL, COND_NV
  } cond_t;

  // ALU operations
  typedef enum logic [3:0] {
    OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD, OP_ADC, OP_SBC, OP_RSC,
    OP_TST, OP_TEQ, OP_CMP, OP_CMN, OP_ORR, OP_MOV, OP_BIC, OP_MVN
  } opcode_t;

  // barrel shifter operations
  typedef enum logic [1:0] {
    SHIFT_LSL, SHIFT_LSR, SHIFT_ASR, SHIFT_ROR
  } shift_t;

  // request kinds
  typedef enum logic {
    KIND_DP, KIND_FLAGS
  } kind_t;

  // flags, N in bit 4 down to Q in bit 0
  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
    logic q;
  } flags_t;

  // shifter control, top to shifter
  typedef struct packed {
    logic [1:0]       shift_type;
    logic [AMT_W-1:0] amount;
    logic             by_register;
    logic             carry_in;
  } shift_ctrl_t;

  // shifter output
  typedef struct packed {
    logic [XLEN-1:0] value;
    logic            carry;
  } shift_res_t;

  // captured request
  typedef struct packed {
    logic             kind;
    logic [3:0]       cond;
    logic [3:0]       opcode;
    logic             set_flags;
    logic [XLEN-1:0]  operand_a;
    logic [XLEN-1:0]  operand_b;
    logic [1:0]       shift_type;
    logic [AMT_W-1:0] shift_amount;
    logic             shift_by_register;
    logic [4:0]       new_flags;
  } req_t;

endpackage

`default_nettype wire

// File: sv/cabsf_in_if.sv
`default_nettype none

interface cabsf_in_if
  import cabsf_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [3:0]       cond;
  logic [3:0]       opcode;
  logic             set_flags;
  logic [XLEN-1:0]  operand_a;
  logic [XLEN-1:0]  operand_b;
  logic [1:0]       shift_type;
  logic [AMT_W-1:0] shift_amount;
  logic             shift_by_register;
  logic [4:0]       new_flags;

  modport source (
    output valid, kind, cond, opcode, set_flags, operand_a, operand_b,
           shift_type, shift_amount, shift_by_register, new_flags,
    input  ready
  );

  modport sink (
    input  valid, kind, cond, opcode, set_flags, operand_a, operand_b,
           shift_type, shift_amount, shift_by_register, new_flags,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/cabsf_out_if.sv
`default_nettype none

interface cabsf_out_if
  import cabsf_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic            cond_passed;
  logic [XLEN-1:0] result;
  logic            result_valid;
  logic [4:0]      flags_nzcvq;

  modport source (
    output valid, cond_passed, result, result_valid, flags_nzcvq,
    input  ready
  );

  modport sink (
    input  valid, cond_passed, result, result_valid, flags_nzcvq,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/cabsf_shifter.sv
`default_nettype none

// Barrel shifter with immediate-amount and register-amount rules.
module cabsf_shifter
  import cabsf_pkg::*;
(
  input  wire logic [XLEN-1:0] x,
  input  wire shift_ctrl_t     ctrl,
  output shift_res_t           res
);

  localparam logic [AMT_W-1:0]   AMT_FULL = AMT_W'(XLEN);
  localparam logic [SHAMT_W:0]   IDX_FULL = (SHAMT_W+1)'(XLEN);

  logic [AMT_W-1:0]   amt;
  logic               rrx;
  logic [SHAMT_W-1:0] a5;
  logic [SHAMT_W-1:0] a5_m1;
  logic [SHAMT_W-1:0] lsl_idx;
  logic [SHAMT_W:0]   lsl_idx_w;
  logic [2*XLEN-1:0]  rot_w;
  logic [XLEN-1:0]    fill;

  // map immediate rules onto register rules
  always_comb begin
    amt = ctrl.amount;
    rrx = 1'b0;
    if (!ctrl.by_register) begin
      amt = {{(AMT_W-SHAMT_W){1'b0}}, ctrl.amount[SHAMT_W-1:0]};
      case (shift_t'(ctrl.shift_type))
        SHIFT_LSR, SHIFT_ASR: begin
          if (ctrl.amount[SHAMT_W-1:0] == '0) amt = AMT_FULL;
        end
        SHIFT_ROR: begin
          if (ctrl.amount[SHAMT_W-1:0] == '0) rrx = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign a5        = amt[SHAMT_W-1:0];
  assign a5_m1     = a5 - SHAMT_W'(1);
  assign lsl_idx_w = IDX_FULL - {1'b0, a5};
  assign lsl_idx   = lsl_idx_w[SHAMT_W-1:0];
  assign rot_w     = {x, x} >> a5;
  assign fill      = {XLEN{x[XLEN-1]}};

  // shift by register rules
  always_comb begin
    res.value = x;
    res.carry = ctrl.carry_in;
    if (rrx) begin
      res.value = {ctrl.carry_in, x[XLEN-1:1]};
      res.carry = x[0];
    end else if (amt != '0) begin
      case (shift_t'(ctrl.shift_type))
        SHIFT_LSL: begin
          if (amt > AMT_FULL) begin
            res.value = '0;
            res.carry = 1'b0;
          end else if (amt == AMT_FULL) begin
            res.value = '0;
            res.carry = x[0];
          end else begin
            res.value = x << a5;
            res.carry = x[lsl_idx];
          end
        end
        SHIFT_LSR: begin
          if (amt > AMT_FULL) begin
            res.value = '0;
            res.carry = 1'b0;
          end else if (amt == AMT_FULL) begin
            res.value = '0;
            res.carry = x[XLEN-1];
          end else begin
            res.value = x >> a5;
            res.carry = x[a5_m1];
          end
        end
        SHIFT_ASR: begin
          if (amt >= AMT_FULL) begin
            res.value = fill;
            res.carry = x[XLEN-1];
          end else begin
            res.value = XLEN'($signed(x) >>> a5);
            res.carry = x[a5_m1];
          end
        end
        default: begin
          // rotate; a multiple of the width keeps the value
          if (a5 == '0) begin
            res.value = x;
            res.carry = x[XLEN-1];
          end else begin
            res.value = rot_w[XLEN-1:0];
            res.carry = x[a5_m1];
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/cond_alu_barrel_shifter_flags_core.sv
// Conditional data-processing ALU with barrel shifter and NZCVQ flags. Each
// request is either one data-processing instruction (condition check against
// the stored flags, shift of operand_b, ALU operation, optional flag update)
// or a direct load of all five flags. One request is accepted per clock
// while the output is not stalled: the request is captured in an input
// register, evaluated in one pass through the shifter and ALU, and written to
// a one-entry output register. The flags live in a register updated as each
// request leaves the input register, so back-to-back requests always see the
// flags left by the one before. Requests keep flowing while a result waits,
// until both registers are full.
`default_nettype none

module cond_alu_barrel_shifter_flags_core
  import cabsf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  cabsf_in_if.sink    in_ch,
  cabsf_out_if.source out_ch
);

`include "cond_alu_barrel_shifter_flags_core_assert.svh"

  // stage registers
  logic   s1_valid;
  req_t   s1;
  logic   out_valid;
  logic   out_passed;
  logic [XLEN-1:0] out_result;
  logic   out_rvalid;
  flags_t out_flags;
  flags_t flags;

  logic   adv;
  logic   cond_ok;
  logic   test_op;
  logic   passed;
  logic   rvalid;
  logic [XLEN-1:0] res;
  flags_t flags_next;
  logic   arith;
  logic [XLEN-1:0] ax;
  logic [XLEN-1:0] ay;
  logic   cin;
  logic [XLEN:0] sum;
  logic [XLEN-1:0] r;

  shift_ctrl_t sh_ctrl;
  shift_res_t  sh;

  // handshake
  assign adv         = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      s1.kind              <= in_ch.kind;
      s1.cond              <= in_ch.cond;
      s1.opcode            <= in_ch.opcode;
      s1.set_flags         <= in_ch.set_flags;
      s1.operand_a         <= in_ch.operand_a;
      s1.operand_b         <= in_ch.operand_b;
      s1.shift_type        <= in_ch.shift_type;
      s1.shift_amount      <= in_ch.shift_amount;
      s1.shift_by_register <= in_ch.shift_by_register;
      s1.new_flags         <= in_ch.new_flags;
    end
  end

  // barrel shifter
  assign sh_ctrl.shift_type  = s1.shift_type;
  assign sh_ctrl.amount      = s1.shift_amount;
  assign sh_ctrl.by_register = s1.shift_by_register;
  assign sh_ctrl.carry_in    = flags.c;

  cabsf_shifter u_shifter (
    .x    (s1.operand_b),
    .ctrl (sh_ctrl),
    .res  (sh)
  );

  // condition check
  always_comb begin
    case (cond_t'(s1.cond))
      COND_EQ: cond_ok = flags.z;
      COND_NE: cond_ok = !flags.z;
      COND_CS: cond_ok = flags.c;
      COND_CC: cond_ok = !flags.c;
      COND_MI: cond_ok = flags.n;
      COND_PL: cond_ok = !flags.n;
      COND_VS: cond_ok = flags.v;
      COND_VC: cond_ok = !flags.v;
      COND_HI: cond_ok = flags.c && !flags.z;
      COND_LS: cond_ok = !(flags.c && !flags.z);
      COND_GE: cond_ok = (flags.n == flags.v);
      COND_LT: cond_ok = (flags.n != flags.v);
      COND_GT: cond_ok = (flags.n == flags.v) && !flags.z;
      COND_LE: cond_ok = !((flags.n == flags.v) && !flags.z);
      COND_AL: cond_ok = 1'b1;
      default: cond_ok = 1'b0;
    endcase
  end

  // ALU operand selection
  always_comb begin
    arith = 1'b0;
    ax    = s1.operand_a;
    ay    = sh.value;
    cin   = 1'b0;
    r     = '0;
    case (opcode_t'(s1.opcode))
      OP_AND, OP_TST: r = s1.operand_a & sh.value;
      OP_EOR, OP_TEQ: r = s1.operand_a ^ sh.value;
      OP_SUB, OP_CMP: begin
        arith = 1'b1; ay = ~sh.value; cin = 1'b1;
      end
      OP_RSB: begin
        arith = 1'b1; ax = ~s1.operand_a; cin = 1'b1;
      end
      OP_ADD, OP_CMN: arith = 1'b1;
      OP_ADC: begin
        arith = 1'b1; cin = flags.c;
      end
      OP_SBC: begin
        arith = 1'b1; ay = ~sh.value; cin = flags.c;
      end
      OP_RSC: begin
        arith = 1'b1; ax = ~s1.operand_a; cin = flags.c;
      end
      OP_ORR: r = s1.operand_a | sh.value;
      OP_MOV: r = sh.value;
      OP_BIC: r = s1.operand_a & ~sh.value;
      default: r = ~sh.value;
    endcase
    sum = {1'b0, ax} + {1'b0, ay} + {{XLEN{1'b0}}, cin};
    if (arith) begin
      r = sum[XLEN-1:0];
    end
  end

  assign test_op = (s1.opcode[3:2] == 2'b10);

  // result and flag update
  always_comb begin
    passed     = 1'b1;
    rvalid     = 1'b0;
    res        = '0;
    flags_next = flags;
    if (kind_t'(s1.kind) == KIND_FLAGS) begin
      flags_next = flags_t'(s1.new_flags);
    end else begin
      passed = cond_ok;
      if (cond_ok && !(test_op && !s1.set_flags)) begin
        if (s1.set_flags) begin
          flags_next.n = r[XLEN-1];
          flags_next.z = (r == '0);
          if (arith) begin
            flags_next.c = sum[XLEN];
            flags_next.v = ~(ax[XLEN-1] ^ ay[XLEN-1]) & (ax[XLEN-1] ^ r[XLEN-1]);
          end else begin
            flags_next.c = sh.carry;
          end
        end
        if (!test_op) begin
          res    = r;
          rvalid = 1'b1;
        end
      end
    end
  end

  // flags and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) flags <= flags_next;
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (adv) begin
      out_passed <= passed;
      out_result <= res;
      out_rvalid <= rvalid;
      out_flags  <= flags_next;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.cond_passed  = out_passed;
  assign out_ch.result       = out_result;
  assign out_ch.result_valid = out_rvalid;
  assign out_ch.flags_nzcvq  = out_flags;

  // checks
  `CABSF_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !out_ch.valid)
  `CABSF_ASSERT(a_written_needs_pass, clk, rst,
    out_ch.valid && out_ch.result_valid |-> out_ch.cond_passed)
  `CABSF_ASSERT(a_unwritten_is_zero, clk, rst,
    out_ch.valid && !out_ch.result_valid |-> out_ch.result == '0)
  `CABSF_ASSERT(a_fail_keeps_flags, clk, rst,
    adv && !passed |=> flags == $past(flags))
  `CABSF_ASSERT(a_q_only_by_write, clk, rst,
    adv && (kind_t'(s1.kind) == KIND_DP) |=> flags.q == $past(flags.q))

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cabsf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_TAIL  = 10;
  localparam int unsigned MAX_REPORTS = 10;

  // one result as it leaves the core
  typedef struct packed {
    logic            cond_passed;
    logic [XLEN-1:0] result;
    logic            result_valid;
    flags_t          flags;
  } alu_result_t;

  // Flag model plus the queue of results still owed by the core.
  class alu_scoreboard;
    flags_t      flags;
    alu_result_t expected_q[$];
    int unsigned mismatches;

    function new();
      flags      = '0;
      mismatches = 0;
    endfunction

    function bit cond_met(cond_t c);
      case (c)
        COND_EQ: return flags.z;
        COND_NE: return !flags.z;
        COND_CS: return flags.c;
        COND_CC: return !flags.c;
        COND_MI: return flags.n;
        COND_PL: return !flags.n;
        COND_VS: return flags.v;
        COND_VC: return !flags.v;
        COND_HI: return flags.c && !flags.z;
        COND_LS: return !(flags.c && !flags.z);
        COND_GE: return flags.n == flags.v;
        COND_LT: return flags.n != flags.v;
        COND_GT: return (flags.n == flags.v) && !flags.z;
        COND_LE: return !((flags.n == flags.v) && !flags.z);
        COND_AL: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    // returns {carry_out, value}
    function bit [XLEN:0] barrel_shift(shift_t st, bit [XLEN-1:0] x, int unsigned amt,
                                       bit by_reg);
      bit [XLEN-1:0] ashr;
      int unsigned   rot;
      // immediate form: 5-bit amount, lsr/asr #0 mean #32, ror #0 is rrx
      if (!by_reg) begin
        amt = amt & 31;
        if ((st == SHIFT_LSR || st == SHIFT_ASR) && amt == 0) amt = 32;
        if (st == SHIFT_ROR && amt == 0) return {x[0], flags.c, x[XLEN-1:1]};
      end
      if (amt == 0) return {flags.c, x};
      case (st)
        SHIFT_LSL: begin
          if (amt > 32) return '0;
          if (amt == 32) return {x[0], {XLEN{1'b0}}};
          return {x[32 - amt], x << amt};
        end
        SHIFT_LSR: begin
          if (amt > 32) return '0;
          if (amt == 32) return {x[XLEN-1], {XLEN{1'b0}}};
          return {x[amt - 1], x >> amt};
        end
        SHIFT_ASR: begin
          if (amt >= 32) return {x[XLEN-1], {XLEN{x[XLEN-1]}}};
          ashr = $signed(x) >>> amt;
          return {x[amt - 1], ashr};
        end
        default: begin
          rot = amt % 32;
          if (rot == 0) return {x[XLEN-1], x};
          return {x[rot - 1], (x >> rot) | (x << (32 - rot))};
        end
      endcase
    endfunction

    // Work out what an accepted request must produce and advance the flags.
    function void note_request(req_t r);
      alu_result_t   e;
      bit [XLEN:0]   shifted;
      bit [XLEN:0]   sum;
      bit [XLEN-1:0] b_sh, x, y, res;
      bit            cin, arith, is_test, passed;
      opcode_t       op;
      e = '0;
      if (kind_t'(r.kind) == KIND_FLAGS) begin
        flags         = flags_t'(r.new_flags);
        e.cond_passed = 1'b1;
      end else begin
        op            = opcode_t'(r.opcode);
        passed        = cond_met(cond_t'(r.cond));
        is_test       = (op == OP_TST || op == OP_TEQ || op == OP_CMP || op == OP_CMN);
        e.cond_passed = passed;
        if (passed && !(is_test && !r.set_flags)) begin
          shifted = barrel_shift(shift_t'(r.shift_type), r.operand_b, 32'(r.shift_amount),
                                 r.shift_by_register);
          b_sh  = shifted[XLEN-1:0];
          arith = 1'b0;
          x     = '0;
          y     = '0;
          cin   = 1'b0;
          res   = '0;
          case (op)
            OP_AND, OP_TST: res = r.operand_a & b_sh;
            OP_EOR, OP_TEQ: res = r.operand_a ^ b_sh;
            OP_SUB, OP_CMP: begin arith = 1'b1; x = r.operand_a;  y = ~b_sh; cin = 1'b1; end
            OP_RSB:         begin arith = 1'b1; x = ~r.operand_a; y = b_sh;  cin = 1'b1; end
            OP_ADD, OP_CMN: begin arith = 1'b1; x = r.operand_a;  y = b_sh;  cin = 1'b0; end
            OP_ADC: begin arith = 1'b1; x = r.operand_a;  y = b_sh;  cin = flags.c; end
            OP_SBC: begin arith = 1'b1; x = r.operand_a;  y = ~b_sh; cin = flags.c; end
            OP_RSC: begin arith = 1'b1; x = ~r.operand_a; y = b_sh;  cin = flags.c; end
            OP_ORR: res = r.operand_a | b_sh;
            OP_MOV: res = b_sh;
            OP_BIC: res = r.operand_a & ~b_sh;
            default: res = ~b_sh;
          endcase
          if (arith) begin
            sum = {1'b0, x} + {1'b0, y} + {{XLEN{1'b0}}, cin};
            res = sum[XLEN-1:0];
            if (r.set_flags) begin
              flags.c = sum[XLEN];
              flags.v = ~(x[XLEN-1] ^ y[XLEN-1]) & (x[XLEN-1] ^ res[XLEN-1]);
            end
          end else if (r.set_flags) begin
            // logical ops take C from the shifter, V is left alone
            flags.c = shifted[XLEN];
          end
          if (r.set_flags) begin
            flags.n = res[XLEN-1];
            flags.z = (res == '0);
          end
          if (!is_test) begin
            e.result       = res;
            e.result_valid = 1'b1;
          end
        end
      end
      e.flags = flags;
      expected_q.push_back(e);
    endfunction

    function void check_result(alu_result_t got);
      alu_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: passed=%0b result=%h valid=%0b flags=%b",
                   got.cond_passed, got.result, got.result_valid, got.flags);
        return;
      end
      e = expected_q.pop_front();
      if (got.cond_passed !== e.cond_passed || got.result !== e.result ||
          got.result_valid !== e.result_valid || got.flags !== e.flags) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"result mismatch: expected passed=%0b result=%h valid=%0b flags=%b,",
                    " got passed=%0b result=%h valid=%0b flags=%b"},
                   e.cond_passed, e.result, e.result_valid, e.flags,
                   got.cond_passed, got.result, got.result_valid, got.flags);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  cabsf_in_if  in_ch ();
  cabsf_out_if out_ch ();

  cond_alu_barrel_shifter_flags_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  alu_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned hold_token  = 0;

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** cond_alu_barrel_shifter_flags_core: FAILED **");
      $finish;
    end
  end

  // Result side: check what was taken, then pick ready for the next edge.
  // Stretches of full throughput alternate with a rotating stall pattern;
  // a hold-off request keeps ready low for a long stretch.
  int unsigned   hold_served  = 0;
  int unsigned   hold_left    = 0;
  int unsigned   seg_left     = 0;
  int unsigned   pattern_left = 0;
  bit            rx_stalling  = 1'b0;
  logic [15:0]   stall_bits   = '1;
  alu_result_t   got;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = {out_ch.cond_passed, out_ch.result, out_ch.result_valid, out_ch.flags_nzcvq};
        sb.check_result(got);
      end
      if (hold_token != hold_served) begin
        hold_served = hold_token;
        hold_left   = HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        seg_left    = $urandom_range(20, 300);
        rx_stalling = ($urandom_range(0, 2) != 0);
      end else begin
        seg_left--;
      end
      if (pattern_left == 0) begin
        stall_bits   = 16'($urandom);
        pattern_left = 16;
      end else begin
        stall_bits = {stall_bits[0], stall_bits[15:1]};
        pattern_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !rx_stalling || stall_bits[0];
      end
    end
  end

  function automatic req_t dp(cond_t c, opcode_t op, bit s, logic [XLEN-1:0] a,
                              logic [XLEN-1:0] b, shift_t st, logic [AMT_W-1:0] amt,
                              bit by_reg);
    req_t r;
    r                   = '0;
    r.kind              = KIND_DP;
    r.cond              = c;
    r.opcode            = op;
    r.set_flags         = s;
    r.operand_a         = a;
    r.operand_b         = b;
    r.shift_type        = st;
    r.shift_amount      = amt;
    r.shift_by_register = by_reg;
    return r;
  endfunction

  function automatic req_t flg(logic [4:0] nzcvq);
    req_t r;
    r           = '0;
    r.kind      = KIND_FLAGS;
    r.new_flags = nzcvq;
    return r;
  endfunction

  // operand values biased toward the corners
  function automatic logic [XLEN-1:0] random_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.kind              = ($urandom_range(0, 99) < 12) ? KIND_FLAGS : KIND_DP;
    r.cond              = ($urandom_range(0, 9) < 4) ? COND_AL : 4'($urandom_range(0, 15));
    r.opcode            = 4'($urandom_range(0, 15));
    r.set_flags         = ($urandom_range(0, 3) != 0);
    r.operand_a         = random_word();
    r.operand_b         = random_word();
    r.shift_type        = 2'($urandom_range(0, 3));
    r.shift_by_register = 1'($urandom_range(0, 1));
    r.new_flags         = 5'($urandom_range(0, 31));
    if (r.shift_by_register) begin
      // register amounts: mostly around the 32 boundary, some multiples of 32
      case ($urandom_range(0, 3))
        0, 1:    r.shift_amount = AMT_W'($urandom_range(0, 33));
        2:       r.shift_amount = AMT_W'(32 * $urandom_range(0, 7) + $urandom_range(0, 1));
        default: r.shift_amount = AMT_W'($urandom_range(0, 255));
      endcase
    end else begin
      r.shift_amount = AMT_W'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) r.shift_amount[4:0] = '0;
    end
    return r;
  endfunction

  // Offer one request and hold it until the core takes it.
  task automatic send(req_t r);
    in_ch.valid             <= 1'b1;
    in_ch.kind              <= r.kind;
    in_ch.cond              <= r.cond;
    in_ch.opcode            <= r.opcode;
    in_ch.set_flags         <= r.set_flags;
    in_ch.operand_a         <= r.operand_a;
    in_ch.operand_b         <= r.operand_b;
    in_ch.shift_type        <= r.shift_type;
    in_ch.shift_amount      <= r.shift_amount;
    in_ch.shift_by_register <= r.shift_by_register;
    in_ch.new_flags         <= r.new_flags;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic pause_sender(int unsigned n);
    if (n == 0) return;
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // random requests in bursts with random gaps
  task automatic run_random(int unsigned count);
    int unsigned left;
    int unsigned burst;
    left = count;
    while (left != 0) begin
      burst = $urandom_range(1, 32);
      if (burst > left) burst = left;
      repeat (burst) send(random_request());
      left -= burst;
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
    end
  endtask

  // main sequence
  initial begin
    rst                     <= 1'b1;
    in_ch.valid             <= 1'b0;
    in_ch.kind              <= 1'b0;
    in_ch.cond              <= '0;
    in_ch.opcode            <= '0;
    in_ch.set_flags         <= 1'b0;
    in_ch.operand_a         <= '0;
    in_ch.operand_b         <= '0;
    in_ch.shift_type        <= '0;
    in_ch.shift_amount      <= '0;
    in_ch.shift_by_register <= 1'b0;
    in_ch.new_flags         <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: flag writes, never and failing conditions, every opcode,
    // shifter corners under both amount rules
    send(flg(5'b11111));
    send(dp(COND_NV, OP_MOV, 1'b1, '0, 32'h1234, SHIFT_LSL, 8'd0, 1'b0));
    send(dp(COND_EQ, OP_MOV, 1'b1, '0, '0, SHIFT_LSL, 8'd0, 1'b0));
    send(flg(5'b00000));
    send(dp(COND_EQ, OP_ADD, 1'b1, 32'h5, 32'h5, SHIFT_LSL, 8'd0, 1'b0));
    send(dp(COND_AL, OP_ADD, 1'b1, '1, 32'h1, SHIFT_LSL, 8'd0, 1'b0));
    send(dp(COND_AL, OP_ADC, 1'b1, 32'h7FFF_FFFF, '0, SHIFT_LSL, 8'd0, 1'b0));
    send(dp(COND_AL, OP_SUB, 1'b1, '0, 32'h1, SHIFT_LSL, 8'd0, 1'b0));
    send(dp(COND_AL, OP_RSB, 1'b1, 32'h1, 32'h8000_0000, SHIFT_LSR, 8'd0, 1'b0));
    send(dp(COND_AL, OP_SBC, 1'b1, 32'h8000_0000, 32'h1, SHIFT_LSL, 8'd31, 1'b0));
    send(dp(COND_AL, OP_RSC, 1'b1, '1, '1, SHIFT_LSR, 8'd1, 1'b0));
    send(dp(COND_AL, OP_AND, 1'b1, '1, 32'h8000_0000, SHIFT_ASR, 8'd0, 1'b0));
    send(dp(COND_AL, OP_EOR, 1'b1, '0, 32'h0000_0003, SHIFT_ROR, 8'd0, 1'b0));
    send(dp(COND_AL, OP_TST, 1'b1, 32'hF0F0_F0F0, 32'h0F0F_0F0F, SHIFT_LSL, 8'd0, 1'b0));
    send(dp(COND_AL, OP_TEQ, 1'b0, '1, '1, SHIFT_LSL, 8'd0, 1'b0));
    send(dp(COND_AL, OP_CMP, 1'b1, 32'h8000_0000, 32'h1, SHIFT_LSL, 8'd0, 1'b0));
    send(dp(COND_AL, OP_CMN, 1'b1, 32'h7FFF_FFFF, 32'h1, SHIFT_LSL, 8'd0, 1'b0));
    send(dp(COND_AL, OP_ORR, 1'b1, '0, 32'h1, SHIFT_LSL, 8'd32, 1'b1));
    send(dp(COND_AL, OP_MOV, 1'b1, '0, '1, SHIFT_LSR, 8'd33, 1'b1));
    send(dp(COND_AL, OP_BIC, 1'b1, '1, 32'h8000_0000, SHIFT_ASR, 8'd255, 1'b1));
    send(dp(COND_AL, OP_MVN, 1'b1, '0, 32'h8000_0001, SHIFT_ROR, 8'd64, 1'b1));
    send(dp(COND_AL, OP_MOV, 1'b1, '0, 32'h1234_5678, SHIFT_ROR, 8'd0, 1'b1));
    send(dp(COND_AL, OP_MOV, 1'b1, '1, '1, SHIFT_LSR, 8'd32, 1'b1));
    send(flg(5'b10101));

    run_random(800);

    // sender idles until the core has returned everything
    wait_drained();

    // long receiver hold-off while requests keep coming, so the core backs up
    hold_token++;
    repeat (40) send(random_request());
    wait_drained();

    run_random(860);

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** cond_alu_barrel_shifter_flags_core: PASSED **");
    end else begin
      $display("** cond_alu_barrel_shifter_flags_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
